// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the elevation color ramp.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ECR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ecr assertion failed");
`define ECR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecr implication failed");
`else
`define ECR_ASSERT(lbl, clk, rst, prop)
`define ECR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/ecr_pkg.sv =====
`default_nettype none
package ecr_pkg;

   localparam int ELEV_WIDTH_DEF = 16;
   localparam int MAXE_W         = 15;
   localparam int NUM_BANDS      = 5;
   localparam int BAND_W         = 3;
   localparam int LEN_W          = 13;   // holds 32767 / 5
   localparam int Q_W            = 7;    // channel steps never exceed 120
   localparam int NUM_W          = LEN_W + Q_W;
   localparam int CH_W           = 8;
   localparam int RECIP_W        = 16;
   localparam int RECIP_SHIFT    = 18;

   localparam logic [MAXE_W-1:0]  MAXE_RESET = 15'h7FFF;
   localparam logic [LEN_W-1:0]   LEN_RESET  = LEN_W'(MAXE_RESET / NUM_BANDS);
   // floor(x / 5) == (x * 52429) >> 18 for every 15-bit x
   localparam logic [RECIP_W-1:0] RECIP_5    = 16'd52429;
   localparam logic [CH_W-1:0]    WATER_BLUE = 8'd128;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef logic [2:0][CH_W-1:0] rgb_type;

   typedef struct packed {
      logic              zero;
      logic              len_zero;
      logic [BAND_W-1:0] band;
      logic [LEN_W-1:0]  off;
   } band_type;

   typedef struct packed {
      logic                       zero;
      logic                       len_zero;
      logic [2:0][NUM_W-1:0]      rem;
      logic [2:0][Q_W-1:0]        quo;
      logic [2:0]                 neg;
      logic [2:0][CH_W-1:0]       lo;
   } div_type;

   // Color stops, index [CH_RED] .. [CH_BLUE]
   function automatic rgb_type stop_rgb(input logic [BAND_W-1:0] idx);
      rgb_type rgb;
      unique case (idx)
         3'd0:    rgb = {8'd0,   8'd60,  8'd0};
         3'd1:    rgb = {8'd0,   8'd96,  8'd0};
         3'd2:    rgb = {8'd0,   8'd120, 8'd60};
         3'd3:    rgb = {8'd0,   8'd96,  8'd120};
         3'd4:    rgb = {8'd0,   8'd0,   8'd120};
         3'd5:    rgb = {8'd120, 8'd120, 8'd120};
         default: rgb = '0;
      endcase
      return rgb;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ecr_if.sv =====
`default_nettype none
interface ecr_req_if #(parameter int ELEVATION_WIDTH = ecr_pkg::ELEV_WIDTH_DEF);
   logic                              valid;
   logic                              ready;
   logic signed [ELEVATION_WIDTH-1:0] elevation;

   modport source (output valid, output elevation, input ready);
   modport sink   (input valid, input elevation, output ready);
endinterface

interface ecr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ecr_pkg::CH_W-1:0]    red;
   logic [ecr_pkg::CH_W-1:0]    green;
   logic [ecr_pkg::CH_W-1:0]    blue;
   logic                        valid_res;

   modport source (output valid, output red, output green, output blue, output valid_res,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input valid_res,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/elevation_color_ramp.sv =====
// Channel   Dir  Handshake            Payload
// req_bus   in   valid / ready        elevation (signed, ELEVATION_WIDTH bits)
// rsp_bus   out  valid / ready        red, green, blue (8 bits each), valid_res
// csr_*     in   csr_we               csr_wdata = max_elevation (15 bits)
//
// One request per cycle unless rsp_bus.ready holds the pipeline back. Stages: three
// classify, one product, seven divider (one quotient bit each) and the output register.
// The divider pipeline retires one request per cycle under the same condition.
// Reset clears all stage valid bits and loads the band length for max_elevation = 32767.
// Each stage takes new data when it is empty or its successor moves, so bubbles
// collapse and requests enter while a response waits on rsp_bus.ready, until all are full.
`default_nettype none
`include "assert_macros.svh"
module elevation_color_ramp #(
   parameter int ELEVATION_WIDTH = ecr_pkg::ELEV_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   ecr_req_if.sink                           req_bus,
   ecr_rsp_if.source                         rsp_bus,
   input  wire logic                         csr_we,
   input  wire logic [ecr_pkg::MAXE_W-1:0]   csr_wdata
);

   localparam int PW = ecr_pkg::MAXE_W + ecr_pkg::RECIP_W;

   logic [ecr_pkg::LEN_W-1:0] len_ff, len_in;
   logic [PW-1:0]             recip_prod;

   logic                      mid_valid, mid_ready;
   ecr_pkg::band_type         mid_band;

   // band length = max_elevation / 5, kept per write
   assign recip_prod = PW'(csr_wdata) * PW'(ecr_pkg::RECIP_5);
   assign len_in     = csr_we ? recip_prod[ecr_pkg::RECIP_SHIFT +: ecr_pkg::LEN_W] : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= ecr_pkg::LEN_RESET;
      end else begin
         len_ff <= len_in;
      end
   end

   ecr_classify #(
      .ELEVATION_WIDTH (ELEVATION_WIDTH)
   ) u_classify (
      .clock        (clock),
      .reset        (reset),
      .len          (len_ff),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .in_elevation (req_bus.elevation),
      .out_valid    (mid_valid),
      .out_ready    (mid_ready),
      .out_band     (mid_band)
   );

   ecr_interp u_interp (
      .clock         (clock),
      .reset         (reset),
      .len           (len_ff),
      .in_valid      (mid_valid),
      .in_ready      (mid_ready),
      .in_band       (mid_band),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .out_red       (rsp_bus.red),
      .out_green     (rsp_bus.green),
      .out_blue      (rsp_bus.blue),
      .out_valid_res (rsp_bus.valid_res)
   );

   `ECR_ASSERT_IMPL(a_novalid_black, clock, reset, rsp_bus.valid && !rsp_bus.valid_res, rsp_bus.red == '0 && rsp_bus.green == '0 && rsp_bus.blue == '0)
   `ECR_ASSERT_IMPL(a_len_gives_color, clock, reset, rsp_bus.valid && len_ff != '0, rsp_bus.valid_res)
   `ECR_ASSERT_IMPL(a_blue_source, clock, reset, rsp_bus.valid && rsp_bus.blue != '0, (rsp_bus.red == '0 && rsp_bus.green == '0 && rsp_bus.blue == ecr_pkg::WATER_BLUE) || rsp_bus.red == 8'd120)

endmodule
`default_nettype wire

// ===== rtl/core/ecr_classify.sv =====
`default_nettype none
module ecr_classify #(
   parameter int ELEVATION_WIDTH = ecr_pkg::ELEV_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [ecr_pkg::LEN_W-1:0]         len,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [ELEVATION_WIDTH-1:0] in_elevation,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output ecr_pkg::band_type                      out_band
);

   localparam int CW = (ELEVATION_WIDTH > 16) ? ELEVATION_WIDTH : 16;
   localparam int MW = ecr_pkg::MAXE_W;

   // stage 1: input register
   logic                              v1_ff;
   logic signed [ELEVATION_WIDTH-1:0] e_ff;
   logic                              rdy1, rdy2, rdy3;

   // stage 2: band select
   logic                              v2_ff;
   logic                              zero_ff, zero_in, lenz_ff, lenz_in;
   logic                              clo_ff, clo_in, chi_ff, chi_in;
   logic [ecr_pkg::BAND_W-1:0]        band2_ff, band2_in;
   logic [MW-1:0]                     e15_ff, e15_in, base_ff, base_in;

   // stage 3: offset inside band
   logic                              v3_ff;
   ecr_pkg::band_type                 band3_ff, band3_in;

   logic [CW-1:0]                     eu;
   logic [MW-1:0]                     m1, m2, m3, m4, m5;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      eu      = CW'(e_ff);
      m1      = MW'(len);
      m2      = m1 << 1;
      m4      = m1 << 2;
      m3      = m2 + m1;
      m5      = m4 + m1;
      zero_in = (e_ff == '0);
      lenz_in = (len == '0);
      e15_in  = eu[MW-1:0];
      clo_in  = 1'b0;
      chi_in  = 1'b0;
      priority if (e_ff[ELEVATION_WIDTH-1]) begin
         clo_in   = 1'b1;
         band2_in = 3'd0;
         base_in  = '0;
      end else if (eu >= CW'(m5)) begin
         chi_in   = 1'b1;
         band2_in = 3'd4;
         base_in  = m4;
      end else if (eu >= CW'(m4)) begin
         band2_in = 3'd4;
         base_in  = m4;
      end else if (eu >= CW'(m3)) begin
         band2_in = 3'd3;
         base_in  = m3;
      end else if (eu >= CW'(m2)) begin
         band2_in = 3'd2;
         base_in  = m2;
      end else if (eu >= CW'(m1)) begin
         band2_in = 3'd1;
         base_in  = m1;
      end else begin
         band2_in = 3'd0;
         base_in  = '0;
      end
   end

   always_comb begin
      logic [MW-1:0] diff;
      diff              = e15_ff - base_ff;
      band3_in.zero     = zero_ff;
      band3_in.len_zero = lenz_ff;
      band3_in.band     = band2_ff;
      priority if (clo_ff)
         band3_in.off = '0;
      else if (chi_ff)
         band3_in.off = len;
      else
         band3_in.off = diff[ecr_pkg::LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         e_ff <= in_elevation;
      end
      if (rdy2) begin
         zero_ff  <= zero_in;
         lenz_ff  <= lenz_in;
         clo_ff   <= clo_in;
         chi_ff   <= chi_in;
         band2_ff <= band2_in;
         e15_ff   <= e15_in;
         base_ff  <= base_in;
      end
      if (rdy3) begin
         band3_ff <= band3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_band  = band3_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ecr_interp.sv =====
`default_nettype none
module ecr_interp (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [ecr_pkg::LEN_W-1:0] len,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire ecr_pkg::band_type         in_band,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [ecr_pkg::CH_W-1:0]       out_red,
   output logic [ecr_pkg::CH_W-1:0]       out_green,
   output logic [ecr_pkg::CH_W-1:0]       out_blue,
   output logic                           out_valid_res
);

   localparam int QW = ecr_pkg::Q_W;
   localparam int NW = ecr_pkg::NUM_W;

   // stage 0 forms |off * step|, stages 1..QW retire one quotient bit each
   logic                [QW:0] v_ff;
   logic                [QW:0] stg_rdy;
   ecr_pkg::div_type           div_ff [0:QW];
   ecr_pkg::div_type           div_in [0:QW];

   logic                       out_v_ff, out_rdy;
   ecr_pkg::rgb_type           rgb_ff, rgb_in;
   logic                       vres_ff, vres_in;

   assign out_rdy     = !out_v_ff || out_ready;
   assign stg_rdy[QW] = !v_ff[QW] || out_rdy;
   assign in_ready    = stg_rdy[0];

   always_comb begin
      ecr_pkg::rgb_type lo_rgb, hi_rgb;
      logic signed [8:0] diff;
      logic [8:0]        mag;
      lo_rgb              = ecr_pkg::stop_rgb(in_band.band);
      hi_rgb              = ecr_pkg::stop_rgb(ecr_pkg::BAND_W'(in_band.band + 1'b1));
      div_in[0].zero      = in_band.zero;
      div_in[0].len_zero  = in_band.len_zero;
      div_in[0].quo       = '0;
      for (int c = 0; c < 3; c++) begin
         diff              = $signed({1'b0, hi_rgb[c]}) - $signed({1'b0, lo_rgb[c]});
         mag               = diff[8] ? 9'(-diff) : 9'(diff);
         div_in[0].neg[c]  = diff[8];
         div_in[0].lo[c]   = lo_rgb[c];
         div_in[0].rem[c]  = NW'(in_band.off) * NW'(mag[QW-1:0]);
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_div
      localparam int K = QW - j;
      assign stg_rdy[j-1] = !v_ff[j-1] || stg_rdy[j];

      always_comb begin
         logic [NW-1:0] trial;
         trial     = NW'(len) << K;
         div_in[j] = div_ff[j-1];
         for (int c = 0; c < 3; c++) begin
            if (div_ff[j-1].rem[c] >= trial) begin
               div_in[j].rem[c]    = div_ff[j-1].rem[c] - trial;
               div_in[j].quo[c][K] = 1'b1;
            end
         end
      end
   end

   for (genvar j = 0; j <= QW; j++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (stg_rdy[j]) begin
            v_ff[j] <= (j == 0) ? in_valid : v_ff[(j == 0) ? 0 : j - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (stg_rdy[j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // negative steps round toward minus infinity: lo - ceil(|num| / len)
   always_comb begin
      logic [ecr_pkg::CH_W-1:0] q8;
      logic                     frac;
      for (int c = 0; c < 3; c++) begin
         q8   = ecr_pkg::CH_W'(div_ff[QW].quo[c]);
         frac = (div_ff[QW].rem[c] != '0);
         if (div_ff[QW].neg[c])
            rgb_in[c] = div_ff[QW].lo[c] - q8 - ecr_pkg::CH_W'(frac);
         else
            rgb_in[c] = div_ff[QW].lo[c] + q8;
      end
      priority if (div_ff[QW].zero) begin
         rgb_in                  = '0;
         rgb_in[ecr_pkg::CH_BLUE] = ecr_pkg::WATER_BLUE;
         vres_in                 = 1'b1;
      end else if (div_ff[QW].len_zero) begin
         rgb_in  = '0;
         vres_in = 1'b0;
      end else begin
         vres_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rgb_ff  <= rgb_in;
         vres_ff <= vres_in;
      end
   end

   assign out_valid     = out_v_ff;
   assign out_red       = rgb_ff[ecr_pkg::CH_RED];
   assign out_green     = rgb_ff[ecr_pkg::CH_GREEN];
   assign out_blue      = rgb_ff[ecr_pkg::CH_BLUE];
   assign out_valid_res = vres_ff;

endmodule
`default_nettype wire

// ===== tb/sv/ecr_checker.sv =====
`default_nettype none
module ecr_checker (
   input  wire logic                       clock,
   input  wire logic                       reset,
   ecr_req_if                              req_mon,
   ecr_rsp_if                              rsp_mon,
   input  wire logic                       csr_we,
   input  wire logic [ecr_pkg::MAXE_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              colors_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ecr_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            valid_res;
   } color_t;

   // ramp stops, {red, green, blue}, lowest elevation first
   localparam int RAMP_STOPS [6][3] = '{
      '{0,   60,  0},
      '{0,   96,  0},
      '{60,  120, 0},
      '{120, 96,  0},
      '{120, 0,   0},
      '{120, 120, 120}
   };

   color_t            expected_colors[$];
   logic [MAXE_W-1:0] max_elev;

   function automatic color_t ramp_color(input logic signed [15:0] elev,
                                         input logic [MAXE_W-1:0] maxe);
      int     span;
      int     band;
      int     offset;
      int     height;
      int     num;
      int     quo;
      int     ch [3];
      color_t c;
      span   = int'(maxe) / NUM_BANDS;
      height = int'(elev);
      c      = '0;
      if (height == 0) begin
         c.blue      = WATER_BLUE;
         c.valid_res = 1'b1;
         return c;
      end
      if (span == 0)
         return c;
      if (height < 0) begin
         band   = 0;
         offset = 0;
      end else begin
         band = height / span;
         if (band >= NUM_BANDS) begin
            band   = NUM_BANDS - 1;
            offset = span;
         end else begin
            offset = height - band * span;
         end
      end
      for (int i = 0; i < 3; i++) begin
         num = offset * (RAMP_STOPS[band+1][i] - RAMP_STOPS[band][i]);
         // round toward minus infinity on falling channels
         if (num >= 0)
            quo = num / span;
         else
            quo = -((-num + span - 1) / span);
         ch[i] = RAMP_STOPS[band][i] + quo;
      end
      c.red       = CH_W'(ch[0]);
      c.green     = CH_W'(ch[1]);
      c.blue      = CH_W'(ch[2]);
      c.valid_res = 1'b1;
      return c;
   endfunction

   task automatic note_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
   endtask

   initial begin
      mismatch_count = 0;
      colors_pending = 0;
      max_elev       = MAXE_RESET;
   end

   always @(posedge clock) begin
      color_t want;
      if (reset) begin
         max_elev = MAXE_RESET;
         expected_colors.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_colors.push_back(ramp_color(req_mon.elevation, max_elev));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_colors.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with no request outstanding", $time);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_mon.red !== want.red)
                  note_mismatch("red", want.red, rsp_mon.red);
               if (rsp_mon.green !== want.green)
                  note_mismatch("green", want.green, rsp_mon.green);
               if (rsp_mon.blue !== want.blue)
                  note_mismatch("blue", want.blue, rsp_mon.blue);
               if (rsp_mon.valid_res !== want.valid_res)
                  note_mismatch("valid_res", want.valid_res, rsp_mon.valid_res);
            end
         end
         if (csr_we)
            max_elev = csr_wdata;
      end
      colors_pending = expected_colors.size();
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ecr_pkg::*;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [MAXE_W-1:0] csr_wdata;
   int                mismatch_count;
   int                colors_pending;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                hold_cycles;
   logic [MAXE_W-1:0] cur_max;

   ecr_req_if #(.ELEVATION_WIDTH(16)) req_bus ();
   ecr_rsp_if                         rsp_bus ();

   elevation_color_ramp #(.ELEVATION_WIDTH(16)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   ecr_checker color_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .colors_pending (colors_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // response side: random back-pressure, or a long hold-off when requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_elevation(input logic signed [15:0] elev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.elevation <= elev;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (colors_pending != 0)
         @(negedge clock);
   endtask

   task automatic write_max(input logic [MAXE_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      cur_max    = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_elevation();
      int span;
      int v;
      span = int'(cur_max) / NUM_BANDS;
      case ($urandom_range(9))
         0:       v = 0;
         1, 2:    v = int'($urandom_range(65535)) - 32768;
         3:       v = -int'($urandom_range(32768, 1));
         8:       v = int'($urandom_range(5)) * span + int'($urandom_range(2)) - 1;
         9:       v = $urandom_range(1) ? 32767 : -32768;
         default: begin
            v = $urandom_range(int'(cur_max) + int'(cur_max) / 8 + 2);
            if (v > 32767)
               v = 32767;
         end
      endcase
      return 16'(v);
   endfunction

   initial begin
      logic [MAXE_W-1:0] settings [8];
      settings = '{15'd32767, 15'd0, 15'd4, 15'd5, 15'd11, 15'd997, 15'd32766, 15'd0};
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.elevation = '0;
      send_idle_pct     = 18;
      recv_idle_pct     = 53;
      hold_cycles       = 0;
      cur_max           = MAXE_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset setting: band length 6553, top of ramp at 32765
      send_elevation(16'sd0);
      send_elevation(16'sd1);
      send_elevation(-16'sd1);
      send_elevation(-16'sd32768);
      send_elevation(16'sd32767);
      send_elevation(16'sd6552);
      send_elevation(16'sd6553);
      send_elevation(16'sd13106);
      send_elevation(16'sd19659);
      send_elevation(16'sd26212);
      send_elevation(16'sd32764);
      send_elevation(16'sd32765);
      send_elevation(16'sd32766);
      send_elevation(16'sh5555);
      // band length zero: only water stays valid
      write_max(15'd3);
      send_elevation(16'sd0);
      send_elevation(16'sd5);
      send_elevation(-16'sd7);
      send_elevation(16'sd32767);
      // band length one
      write_max(15'd5);
      send_elevation(16'sd1);
      send_elevation(16'sd2);
      send_elevation(16'sd3);
      send_elevation(16'sd4);
      send_elevation(16'sd5);
      send_elevation(16'sd6);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 18 : 0;
         for (int k = 0; k < 8; k++) begin
            write_max((k == 7) ? MAXE_W'($urandom_range(32767)) : settings[k]);
            repeat (42) send_elevation(pick_elevation());
         end
      end

      // stall the response side long enough to back up the pipeline
      hold_cycles = 80;
      repeat (40) send_elevation(pick_elevation());
      drain();
      repeat (20) send_elevation(pick_elevation());

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && colors_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
